@@ rtl/cfq_pkg.sv @@
// Shared constants, types and helpers for the circular FIFO queue.
`default_nettype none
package cfq_pkg;

	localparam int DEPTH       = 32;
	localparam int DATA_WIDTH  = 32;
	localparam int MAX_RESULTS = 32;

	localparam int AW       = $clog2(DEPTH);
	localparam int CW       = $clog2(DEPTH + 1);
	localparam int STORE_W  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam int DUMP_MAX = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
	localparam int RW       = $clog2(DUMP_MAX + 1);

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_PEEK   = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_DUMP   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] data_in;
	} req_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] data_out;
		logic        last;
	} rsp_word_t;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
		logic [AW-1:0] n;
		begin
			if (p == AW'(DEPTH - 1))
				n = '0;
			else
				n = p + AW'(1);
			return n;
		end
	endfunction

endpackage
`default_nettype wire

@@ rtl/cfq_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
`default_nettype none
module cfq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/circular_fifo_queue.sv @@
// Top level of the opcode-driven circular FIFO queue.
`default_nettype none
// Ring-buffer FIFO of DEPTH words held in one synchronous RAM. Each request word
// carries an opcode: insert, delete, peek, clear or dump; unused opcodes are
// taken and give no response. Insert, clear, and any request that finds the
// queue full or empty answer straight away, so a run of them goes at one word
// per cycle while the response side keeps up. Delete and peek answer from
// S_EMIT once the RAM read returns, and the next request is taken once the
// queue is back in S_IDLE. Dump reads the RAM and gives one response per stored
// word, oldest first, up to MAX_RESULTS words, at one word per cycle while the
// receiver keeps up; no request is taken until the final word (last set) is
// loaded into the response register. The one-deep response register takes a
// new request in the cycle that the waiting response leaves, and stalls
// requests for as long as the receiver holds that response back.
module circular_fifo_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire cfq_pkg::req_word_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output cfq_pkg::rsp_word_t      rsp
);
	import cfq_pkg::*;

	state_t        state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] tail_q, tail_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] rd_ptr_q, rd_ptr_d;
	logic [RW-1:0] rem_q, rem_d;

	logic          rsp_valid_q;
	rsp_word_t     rsp_q, rsp_d;
	logic          load_rsp;

	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [STORE_W-1:0] ram_rdata;

	logic slot_free, accept;

	cfq_ram #(
		.WIDTH(STORE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(req.data_in[STORE_W-1:0]),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign accept    = req_valid && (state_q == S_IDLE) && slot_free;
	assign req_stall = !((state_q == S_IDLE) && slot_free);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		rd_ptr_d  = rd_ptr_q;
		rem_d     = rem_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = tail_q;
		ram_raddr = head_q;
		load_rsp  = 1'b0;
		rsp_d     = '{status: ST_OK, data_out: '0, last: 1'b1};

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req.opcode) inside
						OP_INSERT: begin
							load_rsp = 1'b1;
							if (count_q == CW'(DEPTH)) begin
								rsp_d.status = ST_FULL;
							end else begin
								ram_we  = 1'b1;
								tail_d  = next_slot(tail_q);
								count_d = count_q + CW'(1);
							end
						end
						OP_DELETE, OP_PEEK: begin
							if (count_q == '0) begin
								load_rsp     = 1'b1;
								rsp_d.status = ST_EMPTY;
							end else begin
								ram_re  = 1'b1;
								rem_d   = RW'(1);
								state_d = S_EMIT;
								if (req.opcode == OP_DELETE) begin
									head_d  = next_slot(head_q);
									count_d = count_q - CW'(1);
								end
							end
						end
						OP_CLEAR: begin
							load_rsp = 1'b1;
							head_d   = '0;
							tail_d   = '0;
							count_d  = '0;
						end
						OP_DUMP: begin
							if (count_q == '0) begin
								load_rsp     = 1'b1;
								rsp_d.status = ST_EMPTY;
							end else begin
								ram_re   = 1'b1;
								rd_ptr_d = next_slot(head_q);
								rem_d    = (count_q > CW'(DUMP_MAX)) ? RW'(DUMP_MAX)
								                                      : RW'(count_q);
								state_d  = S_EMIT;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_EMIT: begin
				// read data stays put until consumed; next read goes out as it leaves
				if (slot_free) begin
					load_rsp       = 1'b1;
					rsp_d.data_out = 32'(ram_rdata);
					rsp_d.last     = (rem_q == RW'(1));
					rem_d          = rem_q - RW'(1);
					if (rem_q == RW'(1)) begin
						state_d = S_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = rd_ptr_q;
						rd_ptr_d  = next_slot(rd_ptr_q);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			rem_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			count_q  <= count_d;
			rd_ptr_q <= rd_ptr_d;
			rem_q    <= rem_d;
			if (load_rsp)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp)
			rsp_q <= rsp_d;
	end

endmodule
`default_nettype wire

@@ sim/tb_circular_fifo_queue.sv @@
// Self-checking testbench for the opcode-driven circular FIFO queue.
module tb_circular_fifo_queue;
	import cfq_pkg::*;

	localparam logic [2:0] OPCODE_SPARE_LO = 3'd5;
	localparam logic [2:0] OPCODE_SPARE_HI = 3'd7;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int DRAIN_CYCLES    = 2 * MAX_RESULTS + 8;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;

	// shadow of the queue contents
	logic [31:0] ring_mem [DEPTH];
	int unsigned ring_head = 0;
	int unsigned ring_tail = 0;
	int unsigned ring_fill = 0;

	rsp_word_t   pending_answers [$];
	rsp_word_t   oldest_answer;
	int unsigned mismatch_count = 0;

	bit          tx_no_idle    = 1'b0;
	int unsigned hold_requests = 0;
	int unsigned hold_served   = 0;

	circular_fifo_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [31:0] pick_data();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 16)
			return '1;
		return $urandom;
	endfunction

	function automatic logic [2:0] pick_opcode(input int unsigned insert_pct,
		input int unsigned delete_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < insert_pct)
			return OP_INSERT;
		if (r < insert_pct + delete_pct)
			return OP_DELETE;
		if (r < insert_pct + delete_pct + 8)
			return OP_PEEK;
		if (r < insert_pct + delete_pct + 14)
			return OP_DUMP;
		if (r < insert_pct + delete_pct + 17)
			return OP_CLEAR;
		return 3'($urandom_range(OPCODE_SPARE_LO, OPCODE_SPARE_HI));
	endfunction

	// works out the response words for one accepted request word
	function automatic void predict_answers(input req_word_t w);
		rsp_word_t   r;
		int unsigned n;
		int unsigned slot;
		r = '0;
		r.last = 1'b1;
		case (w.opcode)
			OP_INSERT: begin
				if (ring_fill == DEPTH) begin
					r.status = ST_FULL;
				end else begin
					ring_mem[ring_tail] = w.data_in;
					ring_tail = (ring_tail + 1) % DEPTH;
					ring_fill++;
					r.status = ST_OK;
				end
				pending_answers.push_back(r);
			end
			OP_DELETE, OP_PEEK: begin
				if (ring_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.status   = ST_OK;
					r.data_out = ring_mem[ring_head];
					if (w.opcode == OP_DELETE) begin
						ring_head = (ring_head + 1) % DEPTH;
						ring_fill--;
					end
				end
				pending_answers.push_back(r);
			end
			OP_CLEAR: begin
				ring_head = 0;
				ring_tail = 0;
				ring_fill = 0;
				r.status  = ST_OK;
				pending_answers.push_back(r);
			end
			OP_DUMP: begin
				if (ring_fill == 0) begin
					r.status = ST_EMPTY;
					pending_answers.push_back(r);
				end else begin
					n = (ring_fill > MAX_RESULTS) ? MAX_RESULTS : ring_fill;
					slot = ring_head;
					for (int unsigned k = 0; k < n; k++) begin
						r.status   = ST_OK;
						r.data_out = ring_mem[slot];
						r.last     = (k + 1 == n);
						pending_answers.push_back(r);
						slot = (slot + 1) % DEPTH;
					end
				end
			end
			default: begin
				// spare opcodes are swallowed silently
			end
		endcase
	endfunction

	// called at a rising edge; returns at the edge where the word is taken
	task automatic send_word(input logic [2:0] op, input logic [31:0] data);
		req_word_t   w;
		int unsigned idle;
		w.opcode  = op;
		w.data_in = data;
		idle = tx_no_idle ? 0 : pick_idle_len();
		if (idle != 0) begin
			req_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		do @(posedge clk); while (req_stall);
		predict_answers(w);
	endtask

	task automatic test_directed_ops();
		send_word(OP_DUMP, '0);
		send_word(OP_DELETE, '0);
		send_word(OP_PEEK, '1);
		send_word(OP_INSERT, '0);
		send_word(OP_INSERT, '1);
		send_word(OP_INSERT, pick_data());
		send_word(OP_PEEK, '0);
		send_word(OP_DUMP, '1);
		send_word(OP_DELETE, '0);
		send_word(OP_DELETE, '0);
		send_word(OP_PEEK, '0);
		send_word(OP_DELETE, '0);
		send_word(OP_DELETE, '0);
		for (int unsigned op = OPCODE_SPARE_LO; op <= OPCODE_SPARE_HI; op++)
			send_word(3'(op), pick_data());
		send_word(OP_INSERT, 32'h5A5A_A5A5);
		send_word(OP_INSERT, 32'hA5A5_5A5A);
		send_word(OP_CLEAR, '1);
		send_word(OP_PEEK, '0);
		send_word(OP_DUMP, '0);
	endtask

	// moves the head off slot zero, then fills so that the tail wraps
	task automatic test_fill_and_wrap();
		repeat (20) send_word(OP_INSERT, pick_data());
		repeat (12) send_word(OP_DELETE, pick_data());
		while (ring_fill < DEPTH)
			send_word(OP_INSERT, pick_data());
		repeat (2) send_word(OP_INSERT, pick_data());
		send_word(OP_DUMP, pick_data());
		send_word(OP_PEEK, pick_data());
		while (ring_fill > 0)
			send_word(OP_DELETE, pick_data());
		send_word(OP_DELETE, pick_data());
		send_word(OP_DUMP, pick_data());
	endtask

	// receiver holds off while the sender keeps pushing back to back
	task automatic test_stalled_receiver();
		tx_no_idle = 1'b1;
		send_word(OP_CLEAR, pick_data());
		hold_requests++;
		repeat (36) send_word(OP_INSERT, pick_data());
		send_word(OP_DUMP, pick_data());
		send_word(OP_CLEAR, pick_data());
		tx_no_idle = 1'b0;
	endtask

	task automatic test_random_traffic();
		int unsigned ins_pct;
		int unsigned del_pct;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 3)
				0: begin ins_pct = 60; del_pct = 20; end
				1: begin ins_pct = 20; del_pct = 60; end
				default: begin ins_pct = 40; del_pct = 40; end
			endcase
			tx_no_idle = ($urandom_range(0, 3) == 0);
			repeat (38) send_word(pick_opcode(ins_pct, del_pct), pick_data());
		end
		tx_no_idle = 1'b0;
	endtask

	initial begin : rsp_stall_gen
		int unsigned span;
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
				hold_served++;
			end else if ($urandom_range(0, 99) < 35) begin
				rsp_stall <= 1'b1;
				span = 1 + pick_idle_len();
				repeat (span - 1) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				span = ($urandom_range(0, 99) < 10) ? $urandom_range(30, 80)
					: $urandom_range(1, 6);
				repeat (span - 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_answers.size() == 0) begin
				$error("unexpected word: status %0d data_out %h last %0b",
					rsp.status, rsp.data_out, rsp.last);
				mismatch_count++;
			end else begin
				oldest_answer = pending_answers.pop_front();
				if (rsp.status !== oldest_answer.status) begin
					$error("status: expected %0d, got %0d", oldest_answer.status, rsp.status);
					mismatch_count++;
				end
				if (rsp.data_out !== oldest_answer.data_out) begin
					$error("data_out: expected %h, got %h", oldest_answer.data_out,
						rsp.data_out);
					mismatch_count++;
				end
				if (rsp.last !== oldest_answer.last) begin
					$error("last: expected %0b, got %0b", oldest_answer.last, rsp.last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : run_tests
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_ops();
		test_fill_and_wrap();
		test_stalled_receiver();
		test_random_traffic();
		req_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		// catches stray words after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
